// ===== sv/chs_pkg.sv =====
// Shared types and constants for the CHS task-file issuer.
package chs_pkg;

    // Request commands.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;

    // Task-file register selects, in the order they are written.
    localparam logic [2:0] REG_DEVCTL  = 3'd0;
    localparam logic [2:0] REG_FEATURE = 3'd1;
    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_SECTOR  = 3'd3;
    localparam logic [2:0] REG_CYL_LO  = 3'd4;
    localparam logic [2:0] REG_CYL_HI  = 3'd5;
    localparam logic [2:0] REG_DRVHEAD = 3'd6;
    localparam logic [2:0] REG_COMMAND = 3'd7;

    // Writes issued per request.
    localparam int BEATS = 8;

    // Fixed register contents.
    localparam logic [7:0] DEVCTL_VALUE    = 8'h00;
    localparam logic [7:0] FEATURE_VALUE   = 8'h00;
    localparam logic [7:0] DRIVE_HEAD_BASE = 8'hA0;

    // Configuration register indexes (byte address bits 3:2).
    localparam logic [1:0] CFG_SPT      = 2'd0;
    localparam logic [1:0] CFG_HEADS    = 2'd1;
    localparam logic [1:0] CFG_READ_OP  = 2'd2;
    localparam logic [1:0] CFG_WRITE_OP = 2'd3;

    // Configuration reset values.
    localparam logic [7:0] SPT_RESET      = 8'd63;
    localparam logic [4:0] HEADS_RESET    = 5'd16;
    localparam logic [7:0] READ_OP_RESET  = 8'd32;
    localparam logic [7:0] WRITE_OP_RESET = 8'd197;

    typedef struct packed {
        logic [1:0]  command;
        logic [27:0] block_address;
        logic [7:0]  sector_count;
    } chs_in_t;

    typedef struct packed {
        logic [2:0] register_select;
        logic [7:0] write_value;
        logic       last_write;
    } chs_out_t;

    // Task-file contents handed from the address pipeline to the write sequencer.
    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  count;
        logic [7:0]  sector;
        logic [15:0] cylinder;
        logic [3:0]  head;
    } chs_tf_t;

endpackage

// ===== sv/chs_div.sv =====
// Pipelined restoring divider, a few quotient bits per stage, with sideband.
module chs_div #(
    parameter int DW  = 28,
    parameter int VW  = 8,
    parameter int SW  = 16,
    parameter int BPS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_num,
    input  logic [VW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_quo,
    output logic [VW-1:0] out_rem,
    output logic [SW-1:0] out_side
);
    localparam int NS = (DW + BPS - 1) / BPS;
    localparam int PW = NS * BPS;

    // The work word holds the unconsumed dividend bits at the top and the
    // quotient bits shifted in at the bottom.
    logic          valid_reg [NS];
    logic [PW-1:0] work_reg  [NS];
    logic [VW-1:0] rem_reg   [NS];
    logic [VW-1:0] den_reg   [NS];
    logic [SW-1:0] side_reg  [NS];

    genvar s;
    for (s = 0; s < NS; s++)
    begin : g_stage
        logic          v_in;
        logic [PW-1:0] w_in;
        logic [VW-1:0] r_in;
        logic [VW-1:0] d_in;
        logic [SW-1:0] sd_in;
        logic [PW-1:0] work_next;
        logic [VW-1:0] rem_next;

        if (s == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign w_in  = PW'(in_num);
            assign r_in  = '0;
            assign d_in  = in_den;
            assign sd_in = in_side;
        end
        else
        begin : g_rest
            assign v_in  = valid_reg[s-1];
            assign w_in  = work_reg[s-1];
            assign r_in  = rem_reg[s-1];
            assign d_in  = den_reg[s-1];
            assign sd_in = side_reg[s-1];
        end

        always_comb
        begin : p_step
            logic [VW:0]   r;
            logic [PW-1:0] w;
            r = {1'b0, r_in};
            w = w_in;
            for (int b = 0; b < BPS; b++)
            begin
                r = {r[VW-1:0], w[PW-1]};
                w = {w[PW-2:0], 1'b0};
                if (r >= {1'b0, d_in})
                begin
                    r    = r - {1'b0, d_in};
                    w[0] = 1'b1;
                end
            end
            work_next = w;
            rem_next  = r[VW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            work_reg[s] <= work_next;
            rem_reg[s]  <= rem_next;
            den_reg[s]  <= d_in;
            side_reg[s] <= sd_in;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_quo   = work_reg[NS-1][DW-1:0];
    assign out_rem   = rem_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ===== sv/chs_emit.sv =====
// Write sequencer: issues the eight task-file writes of one request, one per cycle.
module chs_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  chs_pkg::chs_tf_t  tf,
    output logic              strobe,
    output chs_pkg::chs_out_t result
);
    import chs_pkg::*;

    logic       active_reg;
    logic       active_next;
    logic [2:0] beat_reg;
    logic [2:0] beat_next;
    chs_tf_t    tf_reg;
    logic [7:0] value;

    // A new transaction may load on the cycle the previous one shows its last write.
    always_comb
    begin
        active_next = active_reg;
        beat_next   = beat_reg;
        if (load)
        begin
            active_next = 1'b1;
            beat_next   = REG_DEVCTL;
        end
        else if (active_reg)
        begin
            if (beat_reg == REG_COMMAND)
            begin
                active_next = 1'b0;
            end
            else
            begin
                beat_next = beat_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            beat_reg   <= REG_DEVCTL;
        end
        else
        begin
            active_reg <= active_next;
            beat_reg   <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tf_reg <= tf;
        end
    end

    always_comb
    begin
        case (beat_reg)
            REG_DEVCTL:  value = DEVCTL_VALUE;
            REG_FEATURE: value = FEATURE_VALUE;
            REG_COUNT:   value = tf_reg.count;
            REG_SECTOR:  value = tf_reg.sector;
            REG_CYL_LO:  value = tf_reg.cylinder[7:0];
            REG_CYL_HI:  value = tf_reg.cylinder[15:8];
            REG_DRVHEAD: value = DRIVE_HEAD_BASE | {4'b0000, tf_reg.head};
            REG_COMMAND: value = tf_reg.opcode;
            default:     value = tf_reg.opcode;
        endcase
    end

    assign strobe                 = active_reg;
    assign result.register_select = beat_reg;
    assign result.write_value     = value;
    assign result.last_write      = (beat_reg == REG_COMMAND);

endmodule

// ===== sv/chs_taskfile_issuer_core.sv =====
// Top level of the CHS task-file issuer: configuration, address pipeline and sequencer.
//
//  channel   | signals                          | direction | flow control
//  ----------+----------------------------------+-----------+-----------------------
//  request   | start, busy, request             | in        | taken when start & !busy
//  result    | strobe, result                   | out       | one cycle, no back-pressure
//  config    | psel, penable, pwrite, paddr,    | in/out    | APB, pready tied high
//            | pwdata, prdata, pready           |           |
//
// A read or write request issues eight task-file writes, and busy is high after it is
// taken until the port can accept the next one. Unknown commands are taken in every cycle
// in which busy is low. The first write follows acceptance through the two divider
// pipelines of 4 bits per stage and then the sequencer.
// Reset restores the default geometry and opcodes and empties the pipeline.
// The receiver cannot stall; requests are spaced so that transactions never overlap.
module chs_taskfile_issuer_core #(
    parameter int ADDRESS_BITS = 28
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  chs_pkg::chs_in_t  request,
    output logic              strobe,
    output chs_pkg::chs_out_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import chs_pkg::*;

    localparam int AW = (ADDRESS_BITS < 28) ? ADDRESS_BITS : 28;
    localparam logic [2:0] GAP = 3'(BEATS - 1);

    logic [7:0]    spt_reg;
    logic [4:0]    heads_reg;
    logic [7:0]    read_op_reg;
    logic [7:0]    write_op_reg;
    logic [2:0]    gap_reg;
    logic [2:0]    gap_next;
    logic          accept;
    logic          is_rw;
    logic [7:0]    spt_eff;
    logic [4:0]    heads_eff;
    logic [7:0]    opcode_sel;

    logic          d1_valid;
    logic [AW-1:0] d1_quo;
    logic [7:0]    d1_rem;
    logic [15:0]   d1_side;
    logic [7:0]    sector;
    logic          d2_valid;
    logic [AW-1:0] d2_quo;
    logic [4:0]    d2_rem;
    logic [23:0]   d2_side;
    logic [31:0]   cyl_wide;
    chs_tf_t       tf;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg      <= SPT_RESET;
            heads_reg    <= HEADS_RESET;
            read_op_reg  <= READ_OP_RESET;
            write_op_reg <= WRITE_OP_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[3:2])
                CFG_SPT:      spt_reg      <= pwdata[7:0];
                CFG_HEADS:    heads_reg    <= pwdata[4:0];
                CFG_READ_OP:  read_op_reg  <= pwdata[7:0];
                CFG_WRITE_OP: write_op_reg <= pwdata[7:0];
                default:      spt_reg      <= spt_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_SPT:      prdata = {24'd0, spt_reg};
            CFG_HEADS:    prdata = {27'd0, heads_reg};
            CFG_READ_OP:  prdata = {24'd0, read_op_reg};
            CFG_WRITE_OP: prdata = {24'd0, write_op_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // Admission: each read or write transaction reserves one result slot per task-file write.
    assign busy   = (gap_reg != 3'd0);
    assign accept = start && !busy;
    assign is_rw  = (request.command == CMD_READ) || (request.command == CMD_WRITE);

    always_comb
    begin
        gap_next = gap_reg;
        if (accept && is_rw)
        begin
            gap_next = GAP;
        end
        else if (gap_reg != 3'd0)
        begin
            gap_next = gap_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= 3'd0;
        end
        else
        begin
            gap_reg <= gap_next;
        end
    end

    // A zero geometry register divides as one.
    assign spt_eff    = (spt_reg == 8'd0) ? 8'd1 : spt_reg;
    assign heads_eff  = (heads_reg == 5'd0) ? 5'd1 : heads_reg;
    assign opcode_sel = (request.command == CMD_WRITE) ? write_op_reg : read_op_reg;

    // Block address to track and sector.
    chs_div #(
        .DW (AW),
        .VW (8),
        .SW (16),
        .BPS(4)
    ) u_div_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept && is_rw),
        .in_num   (request.block_address[AW-1:0]),
        .in_den   (spt_eff),
        .in_side  ({opcode_sel, request.sector_count}),
        .out_valid(d1_valid),
        .out_quo  (d1_quo),
        .out_rem  (d1_rem),
        .out_side (d1_side)
    );

    // The remainder is below 255, so the sector number stays within a byte.
    assign sector = d1_rem + 8'd1;

    // Track to cylinder and head.
    chs_div #(
        .DW (AW),
        .VW (5),
        .SW (24),
        .BPS(4)
    ) u_div_cyl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d1_valid),
        .in_num   (d1_quo),
        .in_den   (heads_eff),
        .in_side  ({d1_side, sector}),
        .out_valid(d2_valid),
        .out_quo  (d2_quo),
        .out_rem  (d2_rem),
        .out_side (d2_side)
    );

    assign cyl_wide    = 32'(d2_quo);
    assign tf.opcode   = d2_side[23:16];
    assign tf.count    = d2_side[15:8];
    assign tf.sector   = d2_side[7:0];
    assign tf.cylinder = cyl_wide[15:0];
    assign tf.head     = d2_rem[3:0];

    chs_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (d2_valid),
        .tf    (tf),
        .strobe(strobe),
        .result(result)
    );

    // A read or write transaction holds off the next one.
    a_busy_after_rw: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.command == CMD_READ || request.command == CMD_WRITE)
        |=> busy)
        else $error("busy not raised after a read or write transaction");

    // Writes of one transaction follow each other without a gap.
    a_beats_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_write
        |=> strobe && (result.register_select == 3'($past(result.register_select) + 3'd1)))
        else $error("task-file write sequence broken");

    // The pipeline only delivers when the sequencer is free or finishing.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid |-> (!strobe || result.last_write))
        else $error("transaction delivered while the sequencer was mid-sequence");

endmodule
